// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the key table lookup block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// File: rtl/core/skt_pkg.sv
// Types and codes for the sorted key table lookup block.
// No dependencies; used by sorted_key_table_lookup.
package skt_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_LOAD  = 2'd0;
   localparam opcode_type OP_FIND  = 2'd1;
   localparam opcode_type OP_NTH   = 2'd2;
   localparam opcode_type OP_COUNT = 2'd3;

   typedef logic csr_index_type;

   localparam csr_index_type CSR_ENTRY_COUNT = 1'b0;
   localparam csr_index_type CSR_TABLE_OPEN  = 1'b1;

   localparam int CSR_DATA_W = 9;
   localparam int COUNT_W    = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [31:0]        etype;
      logic signed [15:0] eid;
      logic [31:0]        offset;
      logic [31:0]        length;
   } entry_type;

endpackage

// File: rtl/core/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sorted_key_table_lookup.sv
// Sorted key table: load, binary-search find, nth-of-type and count-of-type.
// Depends on skt_pkg, skt_ram and assert_macros.svh.
//
//  channel | ports                           | direction | handshake
//  req     | req_opcode .. req_ordinal       | in        | req_valid / req_ready
//  rsp     | rsp_status .. rsp_type_count    | out       | rsp_valid / rsp_ready
//  csr     | csr_wr_en, csr_index, csr_wr_data | in      | write on csr_wr_en
//
// One transaction at a time; the single RAM read port serves every operation.
// Find reads the midpoint entry (ST_SRCH_RD), then compares it (ST_SRCH_CM).
// Nth and count read one entry per cycle from the first n entries (n =
// entry_count clamped to TABLE_DEPTH). The next request is taken the cycle
// after the response is loaded, even while that response still waits.
// Synchronous reset clears control state only; table contents start unknown.
`include "assert_macros.svh"

module sorted_key_table_lookup #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  skt_pkg::opcode_type         req_opcode,
   input  logic [7:0]                  req_load_slot,
   input  logic [31:0]                 req_key_type,
   input  logic signed [15:0]          req_key_id,
   input  logic [31:0]                 req_load_offset,
   input  logic [31:0]                 req_load_length,
   input  logic [8:0]                  req_ordinal,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic [7:0]                  rsp_found_index,
   output logic [31:0]                 rsp_found_offset,
   output logic [31:0]                 rsp_found_length,
   output logic [8:0]                  rsp_type_count,

   input  logic                        csr_wr_en,
   input  skt_pkg::csr_index_type      csr_index,
   input  logic [skt_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import skt_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW     = $clog2(TABLE_DEPTH + 1);
   localparam int SW     = NW + 1;
   localparam int XW     = ADDR_W + 8;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SRCH_RD = 3'd1;
   localparam logic [2:0] ST_SRCH_CM = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_RESP    = 3'd4;

   // control and configuration
   logic [2:0]         state_ff, state_in;
   logic [8:0]         entry_count_ff;
   logic               table_open_ff;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   opcode_type         op_ff, op_in;
   logic [31:0]        key_type_ff, key_type_in;
   logic signed [15:0] key_id_ff, key_id_in;
   logic [8:0]         ord_ff, ord_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      idx_ff, idx_in;
   logic [ADDR_W-1:0]  paddr_ff, paddr_in;
   logic [ADDR_W-1:0]  mid_ff, mid_in;
   logic signed [SW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;

   // pending result and response registers
   logic               res_status_ff, res_status_in;
   logic [7:0]         res_index_ff, res_index_in;
   logic [31:0]        res_offset_ff, res_offset_in;
   logic [31:0]        res_length_ff, res_length_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_status_ff;
   logic [7:0]         rsp_index_ff;
   logic [31:0]        rsp_offset_ff;
   logic [31:0]        rsp_length_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // RAM interface
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   entry_type          ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   entry_type          ram_rdata;

   logic               req_fire;
   logic               rsp_load;
   logic [XW-1:0]      slot_ext;
   logic               slot_ok;
   logic [NW-1:0]      n_clamp;
   logic [SW:0]        mid_sum;
   logic [ADDR_W-1:0]  mid_calc;
   logic [XW-1:0]      mid_ext;
   logic [XW-1:0]      paddr_ext;
   logic               scan_issue;
   logic               scan_match;
   logic               key_less;
   logic               key_more;

   skt_ram #(
      .DATA_W ($bits(entry_type)),
      .DEPTH  (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign slot_ext  = XW'(req_load_slot);
   assign slot_ok   = slot_ext < XW'(TABLE_DEPTH);
   assign ram_we    = req_fire && (req_opcode == OP_LOAD) && slot_ok;
   assign ram_waddr = slot_ext[ADDR_W-1:0];
   assign ram_wdata = '{etype: req_key_type, eid: req_key_id,
                        offset: req_load_offset, length: req_load_length};

   assign n_clamp = ({23'd0, entry_count_ff} > 32'(TABLE_DEPTH)) ?
                    NW'(TABLE_DEPTH) : NW'(entry_count_ff);

   // lo and hi are both non-negative whenever a probe is issued
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = mid_sum[ADDR_W:1];
   assign mid_ext   = XW'(mid_ff);
   assign paddr_ext = XW'(paddr_ff);

   assign scan_issue = (state_ff == ST_SCAN) && (idx_ff < n_ff);
   assign scan_match = pend_ff && (ram_rdata.etype == key_type_ff);

   assign key_less = (ram_rdata.etype < key_type_ff) ||
                     ((ram_rdata.etype == key_type_ff) && (ram_rdata.eid < key_id_ff));
   assign key_more = (ram_rdata.etype > key_type_ff) ||
                     ((ram_rdata.etype == key_type_ff) && (ram_rdata.eid > key_id_ff));

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      key_type_in   = key_type_ff;
      key_id_in     = key_id_ff;
      ord_in        = ord_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      paddr_in      = paddr_ff;
      mid_in        = mid_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_offset_in = res_offset_ff;
      res_length_in = res_length_ff;
      res_count_in  = res_count_ff;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_opcode;
               key_type_in   = req_key_type;
               key_id_in     = req_key_id;
               ord_in        = req_ordinal;
               n_in          = n_clamp;
               idx_in        = '0;
               pend_in       = 1'b0;
               cnt_in        = '0;
               seen_in       = '0;
               lo_in         = '0;
               hi_in         = SW'(n_clamp) - SW'(1);
               res_status_in = 1'b0;
               res_index_in  = '0;
               res_offset_in = '0;
               res_length_in = '0;
               res_count_in  = '0;
               case (req_opcode)
                  OP_LOAD: begin
                     state_in = ST_RESP;
                  end
                  OP_FIND: begin
                     if (table_open_ff) begin
                        state_in = ST_SRCH_RD;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  OP_NTH: begin
                     if (table_open_ff && (req_ordinal != '0)) begin
                        state_in = ST_SCAN;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  OP_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SRCH_RD: begin
            if (lo_ff > hi_ff) begin
               res_status_in = 1'b1;
               state_in      = ST_RESP;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = mid_calc;
               mid_in    = mid_calc;
               state_in  = ST_SRCH_CM;
            end
         end

         ST_SRCH_CM: begin
            if (key_less) begin
               lo_in    = SW'(mid_ff) + SW'(1);
               state_in = ST_SRCH_RD;
            end else if (key_more) begin
               hi_in    = SW'(mid_ff) - SW'(1);
               state_in = ST_SRCH_RD;
            end else begin
               res_index_in  = mid_ext[7:0];
               res_offset_in = ram_rdata.offset;
               res_length_in = ram_rdata.length;
               state_in      = ST_RESP;
            end
         end

         ST_SCAN: begin
            // issue the next read while the previous entry is checked
            ram_re    = scan_issue;
            ram_raddr = idx_ff[ADDR_W-1:0];
            pend_in   = scan_issue;
            paddr_in  = idx_ff[ADDR_W-1:0];
            if (scan_issue) begin
               idx_in = idx_ff + NW'(1);
            end
            if (scan_match && (cnt_ff != COUNT_MAX)) begin
               cnt_in = cnt_ff + COUNT_W'(1);
            end
            if (scan_match) begin
               seen_in = seen_ff + COUNT_W'(1);
            end
            if ((op_ff == OP_NTH) && scan_match &&
                ((seen_ff + COUNT_W'(1)) == ord_ff)) begin
               res_index_in  = paddr_ext[7:0];
               res_offset_in = ram_rdata.offset;
               res_length_in = ram_rdata.length;
               pend_in       = 1'b0;
               state_in      = ST_RESP;
            end else if (!pend_ff && !scan_issue) begin
               if (op_ff == OP_COUNT) begin
                  res_count_in = cnt_ff;
               end else begin
                  res_status_in = 1'b1;
               end
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
         table_open_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENTRY_COUNT: entry_count_ff <= csr_wr_data[8:0];
               CSR_TABLE_OPEN:  table_open_ff  <= csr_wr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_type_ff   <= key_type_in;
      key_id_ff     <= key_id_in;
      ord_ff        <= ord_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      paddr_ff      <= paddr_in;
      mid_ff        <= mid_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cnt_ff        <= cnt_in;
      seen_ff       <= seen_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_offset_ff <= res_offset_in;
      res_length_ff <= res_length_in;
      res_count_ff  <= res_count_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_offset_ff <= res_offset_ff;
         rsp_length_ff <= res_length_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_index  = rsp_index_ff;
   assign rsp_found_offset = rsp_offset_ff;
   assign rsp_found_length = rsp_length_ff;
   assign rsp_type_count   = rsp_count_ff;

   `ASSERT_IMPLIES(a_write_idle, clock, reset, ram_we, state_ff == ST_IDLE,
                   "table written outside idle")
   `ASSERT_IMPLIES(a_probe_window, clock, reset, state_ff == ST_SRCH_CM, lo_ff <= hi_ff,
                   "probe compared with an empty search window")
   `ASSERT_IMPLIES(a_pend_scan, clock, reset, pend_ff, state_ff == ST_SCAN,
                   "entry read pending outside a scan")
   `ASSERT_IMPLIES(a_count_bound, clock, reset, state_ff == ST_SCAN,
                   {23'd0, cnt_ff} <= 32'(n_ff), "type count exceeds live entries")
   `ASSERT_NEXT(a_resp_hold, clock, reset,
                (state_ff == ST_RESP) && rsp_valid_ff && !rsp_ready,
                state_ff == ST_RESP, "pending result dropped while output stalled")

endmodule
